### hdl/bfpa_pkg.sv
package bfpa_pkg;

  localparam int LEN_W = 17;
  localparam int LEN_IN_W = 16;
  localparam int DEF_TABLE_ENTRIES = 16;
  localparam int DEF_ADDR_BITS = 16;
  localparam logic [LEN_W-1:0] LEN_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK = 2'd0,
    STAT_NO_FIT = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CK,
    S_SCAN_END,
    S_DQ,
    S_DR_RD,
    S_DR_WR,
    S_INS_RD,
    S_INS_CK,
    S_MAX,
    S_MAX_CK,
    S_DONE
  } state_t;

endpackage

### hdl/bfpa_ram.sv
module bfpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/best_fit_partition_allocator.sv
// Channel  Direction  Ports
// in       input      in_valid, in_ready, in_kind, in_start_addr, in_length
// out      output     out_valid, out_ready, out_status, out_granted_addr,
//                     out_granted_len, out_largest_free, out_free_entries
//
// The time an item takes is set by the single table memory: a scan reads one entry
// at a time through the S_SCAN_RD and S_SCAN_CK states, and each removal or sorted
// insertion moves one entry at a time through a read state and a write state.
// Reset clears the state, the entry count and the output valid flag; the table memory is never cleared.
// A new item is accepted while the previous result still waits for out_ready.
module best_fit_partition_allocator
  import bfpa_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int ADDR_BITS = DEF_ADDR_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_kind,
  input  logic [ADDR_BITS-1:0]               in_start_addr,
  input  logic [LEN_IN_W-1:0]                in_length,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_status,
  output logic [ADDR_BITS-1:0]               out_granted_addr,
  output logic [LEN_W-1:0]                   out_granted_len,
  output logic [LEN_W-1:0]                   out_largest_free,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0] out_free_entries
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int EW = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 1;
  localparam int DW = ADDR_BITS + LEN_W;
  localparam int SW = LEN_W + 2;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [ADDR_BITS-1:0] s_r, s_nxt;
  logic [LEN_IN_W-1:0]  len_r, len_nxt;
  logic                 fa_r, fa_nxt, fb_r, fb_nxt;
  logic [CNT_W-1:0]     a_idx_r, a_idx_nxt, b_idx_r, b_idx_nxt;
  logic [ADDR_BITS-1:0] a_st_r, a_st_nxt, b_st_r, b_st_nxt;
  logic [LEN_W-1:0]     a_len_r, a_len_nxt, b_len_r, b_len_nxt;
  logic                 d1_v_r, d1_v_nxt, d2_v_r, d2_v_nxt, ins_v_r, ins_v_nxt;
  logic [CNT_W-1:0]     d1_idx_r, d1_idx_nxt, d2_idx_r, d2_idx_nxt;
  logic [ADDR_BITS-1:0] ns_r, ns_nxt;
  logic [LEN_W-1:0]     nl_r, nl_nxt;
  logic [1:0]           st_r, st_nxt;
  logic [ADDR_BITS-1:0] ga_r, ga_nxt;
  logic [LEN_W-1:0]     gl_r, gl_nxt;
  logic [LEN_W-1:0]     lg_r, lg_nxt;

  logic                 ov_r, ov_nxt;
  logic [1:0]           os_r, os_nxt;
  logic [ADDR_BITS-1:0] oa_r, oa_nxt;
  logic [LEN_W-1:0]     ol_r, ol_nxt;
  logic [LEN_W-1:0]     olg_r, olg_nxt;
  logic [CNT_W-1:0]     oc_r, oc_nxt;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [DW-1:0]        ram_wdata, ram_rdata;
  logic [ADDR_BITS-1:0] e_st;
  logic [LEN_W-1:0]     e_len;

  logic                 accept;
  logic                 last_scan;
  logic [EW-1:0]        rel_end, e_end;
  logic                 alloc_hit, a_hit, b_hit;
  logic                 goes_before;
  logic                 out_free;
  logic [LEN_W-1:0]     cut_diff;
  logic [SW-1:0]        sum3;
  logic [LEN_W-1:0]     sat3, sat_a, sat_b;

  bfpa_ram #(
    .WIDTH(DW),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign e_st = ram_rdata[DW-1:LEN_W];
  assign e_len = ram_rdata[LEN_W-1:0];
  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !ov_r || out_ready;
  assign last_scan = ((idx_r + CNT_W'(1)) == cnt_r);

  assign rel_end = EW'(s_r) + EW'(len_r);
  assign e_end = EW'(e_st) + EW'(e_len);
  assign alloc_hit = (e_len >= LEN_W'(len_r));
  assign a_hit = (EW'(e_st) == rel_end);
  assign b_hit = (e_end == EW'(s_r));
  assign goes_before = (nl_r < e_len) || ((nl_r == e_len) && (ns_r < e_st));

  assign cut_diff = a_len_r - LEN_W'(len_r);
  assign sum3 = SW'(b_len_r) + SW'(len_r) + SW'(a_len_r);
  assign sat3 = (sum3 > SW'(LEN_MAX)) ? LEN_MAX : sum3[LEN_W-1:0];
  assign sat_a = ((SW'(a_len_r) + SW'(len_r)) > SW'(LEN_MAX)) ? LEN_MAX :
                 LEN_W'(SW'(a_len_r) + SW'(len_r));
  assign sat_b = ((SW'(b_len_r) + SW'(len_r)) > SW'(LEN_MAX)) ? LEN_MAX :
                 LEN_W'(SW'(b_len_r) + SW'(len_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if ((in_length == '0) || (in_kind != KIND_ADD && in_kind != KIND_ALLOC &&
              in_kind != KIND_RELEASE)) begin
            state_nxt = S_MAX;
          end else if (in_kind == KIND_ADD) begin
            state_nxt = (cnt_r == CNT_W'(TABLE_ENTRIES)) ? S_MAX : S_INS_RD;
          end else begin
            state_nxt = (cnt_r == '0) ? S_SCAN_END : S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CK;
      S_SCAN_CK: begin
        if ((kind_r == KIND_ALLOC && alloc_hit) || last_scan) begin
          state_nxt = S_SCAN_END;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_END: state_nxt = S_DQ;
      S_DQ: begin
        if (d1_v_r) begin
          state_nxt = S_DR_RD;
        end else if (ins_v_r) begin
          state_nxt = S_INS_RD;
        end else begin
          state_nxt = S_MAX;
        end
      end
      S_DR_RD: state_nxt = ((idx_r + CNT_W'(1)) >= cnt_r) ? S_DQ : S_DR_WR;
      S_DR_WR: state_nxt = S_DR_RD;
      S_INS_RD: state_nxt = (idx_r == '0) ? S_MAX : S_INS_CK;
      S_INS_CK: state_nxt = goes_before ? S_INS_RD : S_MAX;
      S_MAX: state_nxt = (cnt_r == '0) ? S_DONE : S_MAX_CK;
      S_MAX_CK: state_nxt = S_DONE;
      S_DONE: state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    kind_nxt = kind_r;
    s_nxt = s_r;
    len_nxt = len_r;
    fa_nxt = fa_r;
    fb_nxt = fb_r;
    a_idx_nxt = a_idx_r;
    b_idx_nxt = b_idx_r;
    a_st_nxt = a_st_r;
    b_st_nxt = b_st_r;
    a_len_nxt = a_len_r;
    b_len_nxt = b_len_r;
    d1_v_nxt = d1_v_r;
    d2_v_nxt = d2_v_r;
    ins_v_nxt = ins_v_r;
    d1_idx_nxt = d1_idx_r;
    d2_idx_nxt = d2_idx_r;
    ns_nxt = ns_r;
    nl_nxt = nl_r;
    st_nxt = st_r;
    ga_nxt = ga_r;
    gl_nxt = gl_r;
    lg_nxt = lg_r;
    ov_nxt = ov_r && !out_ready;
    os_nxt = os_r;
    oa_nxt = oa_r;
    ol_nxt = ol_r;
    olg_nxt = olg_r;
    oc_nxt = oc_r;
    ram_we = 1'b0;
    ram_waddr = idx_r[IDX_W-1:0];
    ram_wdata = {e_st, e_len};
    ram_raddr = idx_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt = in_kind;
          s_nxt = in_start_addr;
          len_nxt = in_length;
          st_nxt = STAT_OK;
          ga_nxt = '0;
          gl_nxt = '0;
          fa_nxt = 1'b0;
          fb_nxt = 1'b0;
          d1_v_nxt = 1'b0;
          d2_v_nxt = 1'b0;
          ins_v_nxt = 1'b0;
          idx_nxt = '0;
          if (in_kind == KIND_ADD && in_length != '0) begin
            if (cnt_r == CNT_W'(TABLE_ENTRIES)) begin
              st_nxt = STAT_FULL;
            end
            idx_nxt = cnt_r;
            ns_nxt = in_start_addr;
            nl_nxt = LEN_W'(in_length);
          end
        end
      end
      S_SCAN_RD: ram_raddr = idx_r[IDX_W-1:0];
      S_SCAN_CK: begin
        if (kind_r == KIND_ALLOC) begin
          if (alloc_hit) begin
            fa_nxt = 1'b1;
            a_idx_nxt = idx_r;
            a_st_nxt = e_st;
            a_len_nxt = e_len;
          end
        end else begin
          if (!fa_r && a_hit) begin
            fa_nxt = 1'b1;
            a_idx_nxt = idx_r;
            a_len_nxt = e_len;
          end
          if (!fb_r && b_hit) begin
            fb_nxt = 1'b1;
            b_idx_nxt = idx_r;
            b_st_nxt = e_st;
            b_len_nxt = e_len;
          end
        end
        idx_nxt = idx_r + CNT_W'(1);
      end
      S_SCAN_END: begin
        if (kind_r == KIND_ALLOC) begin
          if (!fa_r) begin
            st_nxt = STAT_NO_FIT;
          end else begin
            ga_nxt = a_st_r;
            d1_v_nxt = 1'b1;
            d1_idx_nxt = a_idx_r;
            if (cut_diff <= LEN_W'(1)) begin
              gl_nxt = a_len_r;
            end else begin
              gl_nxt = LEN_W'(len_r);
              ins_v_nxt = 1'b1;
              ns_nxt = ADDR_BITS'(EW'(a_st_r) + EW'(len_r));
              nl_nxt = cut_diff;
            end
          end
        end else begin
          ins_v_nxt = 1'b1;
          if (fa_r && fb_r) begin
            ns_nxt = b_st_r;
            nl_nxt = sat3;
            d1_v_nxt = 1'b1;
            d2_v_nxt = 1'b1;
            d1_idx_nxt = (a_idx_r > b_idx_r) ? a_idx_r : b_idx_r;
            d2_idx_nxt = (a_idx_r > b_idx_r) ? b_idx_r : a_idx_r;
          end else if (fa_r) begin
            ns_nxt = s_r;
            nl_nxt = sat_a;
            d1_v_nxt = 1'b1;
            d1_idx_nxt = a_idx_r;
          end else if (fb_r) begin
            ns_nxt = b_st_r;
            nl_nxt = sat_b;
            d1_v_nxt = 1'b1;
            d1_idx_nxt = b_idx_r;
          end else if (cnt_r == CNT_W'(TABLE_ENTRIES)) begin
            st_nxt = STAT_FULL;
            ins_v_nxt = 1'b0;
          end else begin
            ns_nxt = s_r;
            nl_nxt = LEN_W'(len_r);
          end
        end
      end
      S_DQ: begin
        if (d1_v_r) begin
          idx_nxt = d1_idx_r;
        end else if (ins_v_r) begin
          idx_nxt = cnt_r;
          ins_v_nxt = 1'b0;
        end
      end
      S_DR_RD: begin
        if ((idx_r + CNT_W'(1)) >= cnt_r) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          d1_v_nxt = d2_v_r;
          d1_idx_nxt = d2_idx_r;
          d2_v_nxt = 1'b0;
        end else begin
          ram_raddr = IDX_W'(idx_r + CNT_W'(1));
        end
      end
      S_DR_WR: begin
        ram_we = 1'b1;
        ram_waddr = idx_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        idx_nxt = idx_r + CNT_W'(1);
      end
      S_INS_RD: begin
        if (idx_r == '0) begin
          ram_we = 1'b1;
          ram_waddr = '0;
          ram_wdata = {ns_r, nl_r};
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          ram_raddr = IDX_W'(idx_r - CNT_W'(1));
        end
      end
      S_INS_CK: begin
        ram_we = 1'b1;
        ram_waddr = idx_r[IDX_W-1:0];
        if (goes_before) begin
          ram_wdata = ram_rdata;
          idx_nxt = idx_r - CNT_W'(1);
        end else begin
          ram_wdata = {ns_r, nl_r};
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_MAX: begin
        lg_nxt = '0;
        ram_raddr = IDX_W'(cnt_r - CNT_W'(1));
      end
      S_MAX_CK: lg_nxt = e_len;
      S_DONE: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          os_nxt = st_r;
          oa_nxt = ga_r;
          ol_nxt = gl_r;
          olg_nxt = lg_r;
          oc_nxt = cnt_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    kind_r <= kind_nxt;
    s_r <= s_nxt;
    len_r <= len_nxt;
    fa_r <= fa_nxt;
    fb_r <= fb_nxt;
    a_idx_r <= a_idx_nxt;
    b_idx_r <= b_idx_nxt;
    a_st_r <= a_st_nxt;
    b_st_r <= b_st_nxt;
    a_len_r <= a_len_nxt;
    b_len_r <= b_len_nxt;
    d1_v_r <= d1_v_nxt;
    d2_v_r <= d2_v_nxt;
    ins_v_r <= ins_v_nxt;
    d1_idx_r <= d1_idx_nxt;
    d2_idx_r <= d2_idx_nxt;
    ns_r <= ns_nxt;
    nl_r <= nl_nxt;
    st_r <= st_nxt;
    ga_r <= ga_nxt;
    gl_r <= gl_nxt;
    lg_r <= lg_nxt;
    os_r <= os_nxt;
    oa_r <= oa_nxt;
    ol_r <= ol_nxt;
    olg_r <= olg_nxt;
    oc_r <= oc_nxt;
  end

  assign out_valid = ov_r;
  assign out_status = os_r;
  assign out_granted_addr = oa_r;
  assign out_granted_len = ol_r;
  assign out_largest_free = olg_r;
  assign out_free_entries = oc_r;

endmodule

### hdl/bfpa_chk.sv
module bfpa_chk
  import bfpa_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int ADDR_BITS = DEF_ADDR_BITS
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [1:0]                         out_status,
  input logic [ADDR_BITS-1:0]               out_granted_addr,
  input logic [LEN_W-1:0]                   out_granted_len,
  input logic [LEN_W-1:0]                   out_largest_free,
  input logic [$clog2(TABLE_ENTRIES+1)-1:0] out_free_entries
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_granted_len) && $stable(out_free_entries))
    else $error("result changed while stalled");

  a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |->
    out_granted_addr == '0 && out_granted_len == '0)
    else $error("grant reported on failed item");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_free_entries <= ($clog2(TABLE_ENTRIES+1))'(TABLE_ENTRIES))
    else $error("free entry count out of range");

  a_empty_largest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_free_entries == '0 |-> out_largest_free == '0)
    else $error("largest block reported on empty table");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |->
    out_free_entries == ($clog2(TABLE_ENTRIES+1))'(TABLE_ENTRIES))
    else $error("table full reported below capacity");

endmodule

bind best_fit_partition_allocator bfpa_chk #(
  .TABLE_ENTRIES(TABLE_ENTRIES),
  .ADDR_BITS(ADDR_BITS)
) u_bfpa_chk (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_status(out_status),
  .out_granted_addr(out_granted_addr),
  .out_granted_len(out_granted_len),
  .out_largest_free(out_largest_free),
  .out_free_entries(out_free_entries)
);
